[src/sha_pkg.sv]
`default_nettype none
package sha_pkg;

    localparam int WordW = 32;
    localparam int CvWords = 8;
    localparam int BlockBytes = 64;
    localparam int Rounds = 64;
    localparam int ByteCountW = 61;
    localparam int LenBytePos = 56;
    localparam logic [7:0] PadByte = 8'h80;
    localparam int ModeDefault = 0;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic start;
        logic load_iv;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_sts_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_value(input logic mode224, input logic [2:0] i);
        word_t v;
        case ({mode224, i})
            4'd0: v = 32'h6a09e667; 4'd1: v = 32'hbb67ae85; 4'd2: v = 32'h3c6ef372;
            4'd3: v = 32'ha54ff53a; 4'd4: v = 32'h510e527f; 4'd5: v = 32'h9b05688c;
            4'd6: v = 32'h1f83d9ab; 4'd7: v = 32'h5be0cd19; 4'd8: v = 32'hc1059ed8;
            4'd9: v = 32'h367cd507; 4'd10: v = 32'h3070dd17; 4'd11: v = 32'hf70e5939;
            4'd12: v = 32'hffc00b31; 4'd13: v = 32'h68581511; 4'd14: v = 32'h64f98fa7;
            default: v = 32'hbefa4fa4;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[src/sha_datapath.sv]
`default_nettype none
module sha_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       mode224,
    input  wire sha_pkg::dp_cmd_t           cmd,
    input  wire logic [511:0]               block,
    input  wire logic [2:0]                 emit_index,
    output sha_pkg::dp_sts_t                sts,
    output sha_pkg::word_t                  emit_word
);

    sha_pkg::word_t cv_reg [sha_pkg::CvWords];
    sha_pkg::word_t v_reg [sha_pkg::CvWords];
    sha_pkg::word_t w_reg [16];
    logic [5:0] round_reg;
    logic busy_reg;
    logic last_reg;

    function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int c);
        return (x >> c) | (x << (32 - c));
    endfunction

    sha_pkg::word_t w_cur, s0, s1, t1, t2, wn;

    always_comb
    begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (round_reg < 6'd16) ? w_reg[0] : wn;
        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + sha_pkg::round_k(round_reg) + w_cur;
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // 16-word window; w_reg[0] is the round word up to round 15
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < sha_pkg::CvWords; i++)
                cv_reg[i] <= sha_pkg::init_value(1'b0, 3'(i));
        end
        else if (cmd.load_iv)
        begin
            for (int i = 0; i < sha_pkg::CvWords; i++)
                cv_reg[i] <= sha_pkg::init_value(mode224, 3'(i));
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            last_reg <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < sha_pkg::CvWords; i++)
                v_reg[i] <= cv_reg[i];
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
        end
        else if (busy_reg)
        begin
            if (last_reg)
            begin
                busy_reg <= 1'b0;
                last_reg <= 1'b0;
                for (int i = 0; i < sha_pkg::CvWords; i++)
                    cv_reg[i] <= cv_reg[i] + v_reg[i];
            end
            else
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_cur;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(sha_pkg::Rounds - 1))
                    last_reg <= 1'b1;
            end
        end
    end

    assign sts.busy = busy_reg | cmd.start;
    assign emit_word = cv_reg[emit_index];

endmodule
`default_nettype wire

[src/sha_control.sv]
`default_nettype none
module sha_control (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       kind,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       cfg_write,
    input  wire logic                       mode224,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [2:0]                      word_index,
    output logic                            last_word,
    output sha_pkg::dp_cmd_t                cmd,
    input  wire sha_pkg::dp_sts_t           sts,
    output logic [511:0]                    block
);

    typedef enum logic [2:0] {
        IDLE, HASH, PAD2, HASH_FIN, EMIT
    } state_t;

    state_t state_reg;
    logic [511:0] buf_reg;
    logic [5:0] fill_reg;
    logic [sha_pkg::ByteCountW-1:0] count_reg;
    logic [63:0] bits_reg;
    logic [2:0] idx_reg;
    logic out_valid_reg;
    logic start_reg;
    logic load_reg;

    assign block = buf_reg;
    assign cmd.start = start_reg;
    assign cmd.load_iv = load_reg;
    assign in_stall = (state_reg != IDLE) | start_reg;
    assign out_valid = out_valid_reg;
    assign word_index = idx_reg;
    assign last_word = idx_reg == (mode224 ? 3'd6 : 3'd7);

    function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                          input logic [7:0] v);
        logic [511:0] r;
        r = b;
        r[511 - 8*p -: 8] = v;
        return r;
    endfunction

    function automatic logic [511:0] pad_from(input logic [511:0] b, input logic [5:0] p);
        logic [511:0] r;
        r = b;
        for (int i = 0; i < sha_pkg::BlockBytes; i++)
            if (i > int'(p))
                r[511 - 8*i -: 8] = 8'h00;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            fill_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            start_reg <= 1'b0;
            load_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            load_reg <= 1'b0;
            if (cfg_write)
            begin
                fill_reg <= '0;
                count_reg <= '0;
                load_reg <= 1'b1;
            end
            else
            case (state_reg)
                IDLE:
                begin
                    if (in_valid && !start_reg)
                    begin
                        if (!kind)
                        begin
                            buf_reg <= put(buf_reg, fill_reg, data_byte);
                            fill_reg <= fill_reg + 6'd1;
                            count_reg <= count_reg + 1'b1;
                            if (fill_reg == 6'd63)
                            begin
                                start_reg <= 1'b1;
                                state_reg <= HASH;
                            end
                        end
                        else
                        begin
                            bits_reg <= {count_reg, 3'b000};
                            buf_reg <= pad_from(put(buf_reg, fill_reg, sha_pkg::PadByte),
                                                fill_reg);
                            if (fill_reg >= 6'(sha_pkg::LenBytePos))
                            begin
                                start_reg <= 1'b1;
                                state_reg <= PAD2;
                            end
                            else
                                state_reg <= HASH_FIN;
                        end
                    end
                end
                HASH:
                    if (!sts.busy)
                        state_reg <= IDLE;
                PAD2:
                    if (!sts.busy)
                    begin
                        buf_reg <= '0;
                        state_reg <= HASH_FIN;
                    end
                HASH_FIN:
                begin
                    if (!start_reg && !sts.busy && !out_valid_reg)
                    begin
                        buf_reg[63:0] <= bits_reg;
                        start_reg <= 1'b1;
                        out_valid_reg <= 1'b0;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (!start_reg && !sts.busy)
                    begin
                        if (!out_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            idx_reg <= '0;
                        end
                        else if (!out_stall)
                        begin
                            if (last_word)
                            begin
                                out_valid_reg <= 1'b0;
                                fill_reg <= '0;
                                count_reg <= '0;
                                load_reg <= 1'b1;
                                state_reg <= IDLE;
                            end
                            else
                                idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/sha256_224_stream_digest_core.sv]
// SHA-256 / SHA-224 streaming hasher. Each input transaction appends one byte
// (kind 0) or finishes the message (kind 1). Bytes are accepted while in_stall is low; the 64th
// byte of a block starts the compression, one round per cycle on a single round
// unit, during which input is stalled. Finish pads the message,
// runs one or two compressions, then emits 8 (or 7 in SHA-224 mode) digest words
// one per transaction, last_word marking the final one, and restarts the state.
// Writing the mode register abandons the current message; write it only when idle.
`default_nettype none
module sha256_224_stream_digest_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        truncated_224_mode
);

    logic mode_reg;
    logic cfg_write;
    sha_pkg::dp_cmd_t cmd;
    sha_pkg::dp_sts_t sts;
    logic [511:0] block;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'(sha_pkg::ModeDefault);
        else if (cfg_write)
            mode_reg <= truncated_224_mode;
    end

    sha_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .data_byte(data_byte), .cfg_write(cfg_write),
        .mode224(mode_reg), .out_stall(out_stall), .out_valid(out_valid),
        .word_index(word_index), .last_word(last_word), .cmd(cmd), .sts(sts),
        .block(block)
    );

    sha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .mode224(cfg_write ? truncated_224_mode : mode_reg),
        .cmd(cmd), .block(block), .emit_index(word_index), .sts(sts),
        .emit_word(digest_word)
    );

endmodule
`default_nettype wire
